FILE: hw/rtl/slc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the source line classifier
// no dependencies; used by every other file of the block but slc_ifs
package slc_pkg;

  localparam int COUNT_BITS_DEFAULT = 24;
  localparam int OUT_BITS           = 24;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // request codes
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // characters of interest
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_SEMI   = 8'h3B;
  localparam logic [7:0] CHAR_LBRACE = 8'h7B;
  localparam logic [7:0] CHAR_RBRACE = 8'h7D;

  // code character counter: 3 means three or more
  localparam logic [1:0] CODE_CNT_MAX = 2'd3;

  // decoded item as it travels through the queue
  typedef struct packed {
    logic       is_end;
    logic [7:0] byte_value;
    logic       is_space;
    logic       is_nl;
    logic       is_slash;
    logic       is_star;
    logic       is_dquote;
    logic       is_squote;
    logic       is_punct;
  } item_t;

endpackage

FILE: hw/rtl/slc_ifs.sv
`timescale 1ns / 1ps
// valid/ready channels of the source line classifier: text in, counts out
// depends on nothing
interface slc_text_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] byte_value;

  modport source (output valid, output req_type, output byte_value, input ready);
  modport sink   (input valid, input req_type, input byte_value, output ready);
endinterface

interface slc_count_if;
  logic        valid;
  logic        ready;
  logic [23:0] comment_lines;
  logic [23:0] code_lines;
  logic [23:0] blank_lines;
  logic        empty_text;

  modport source (output valid, output comment_lines, output code_lines,
                  output blank_lines, output empty_text, input ready);
  modport sink   (input valid, input comment_lines, input code_lines,
                  input blank_lines, input empty_text, output ready);
endinterface

FILE: hw/rtl/slc_front.sv
`timescale 1ns / 1ps
// front end: takes text items and classifies each byte for the back end
// depends on slc_pkg and slc_ifs
module slc_front (
  input  logic          rst,
  slc_text_if.sink      text,
  input  logic          queue_full,
  output logic          push,
  output slc_pkg::item_t item
);

  logic [7:0] b;

  assign b          = text.byte_value;
  assign text.ready = !rst && !queue_full;
  assign push       = text.valid && text.ready;

  always_comb begin
    item.is_end     = (text.req_type == slc_pkg::REQ_END);
    item.byte_value = b;
    item.is_space   = (b == slc_pkg::CHAR_SPACE) || (b == slc_pkg::CHAR_TAB);
    item.is_nl      = (b == slc_pkg::CHAR_NL);
    item.is_slash   = (b == slc_pkg::CHAR_SLASH);
    item.is_star    = (b == slc_pkg::CHAR_STAR);
    item.is_dquote  = (b == slc_pkg::CHAR_DQUOTE);
    item.is_squote  = (b == slc_pkg::CHAR_SQUOTE);
    item.is_punct   = (b == slc_pkg::CHAR_LBRACE) || (b == slc_pkg::CHAR_RBRACE) ||
                      (b == slc_pkg::CHAR_SEMI);
  end

endmodule

FILE: hw/rtl/slc_queue.sv
`timescale 1ns / 1ps
// short queue of classified items between front and back end
// depends on slc_pkg
module slc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  slc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output slc_pkg::item_t head_item
);

  slc_pkg::item_t                      entries [slc_pkg::QUEUE_DEPTH];
  logic [slc_pkg::QUEUE_AW-1:0]        wr_ptr;
  logic [slc_pkg::QUEUE_AW-1:0]        rd_ptr;
  logic [slc_pkg::QUEUE_CW-1:0]        count;

  localparam logic [slc_pkg::QUEUE_AW-1:0] LAST_PTR =
    slc_pkg::QUEUE_AW'(slc_pkg::QUEUE_DEPTH - 1);
  localparam logic [slc_pkg::QUEUE_CW-1:0] FULL_COUNT =
    slc_pkg::QUEUE_CW'(slc_pkg::QUEUE_DEPTH);

  assign full       = (count == FULL_COUNT);
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/slc_back.sv
`timescale 1ns / 1ps
// back end: line state machine, saturating line counters and result register
// depends on slc_pkg and slc_ifs
module slc_back #(
  parameter int COUNT_BITS = slc_pkg::COUNT_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  slc_pkg::item_t head_item,
  output logic           pop,
  slc_count_if.source    counts
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [7:0]            prev_byte, prev_byte_next;
  logic                  in_lc, in_lc_next;
  logic                  in_bc, in_bc_next;
  logic                  com_on_line, com_on_line_next;
  logic                  in_dq, in_dq_next;
  logic                  in_sq, in_sq_next;
  logic [1:0]            code_cnt, code_cnt_next;
  logic                  first_punct, first_punct_next;
  logic                  saw_any, saw_any_next;
  logic [COUNT_BITS-1:0] comment_total, comment_total_next;
  logic [COUNT_BITS-1:0] code_total, code_total_next;
  logic [COUNT_BITS-1:0] blank_total, blank_total_next;

  logic                  out_valid;
  logic                  out_free;
  logic                  out_load;
  logic                  end_line;
  logic                  lone_punct;
  logic                  empty_res;
  logic [31:0]           comment_wide, code_wide, blank_wide;
  logic [23:0]           comment_lines, code_lines, blank_lines;
  logic                  empty_text;
  slc_pkg::item_t        it;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
  endfunction

  assign it       = head_item;
  assign out_free = !out_valid || counts.ready;
  assign pop      = head_valid && (!it.is_end || out_free);

  always_comb begin
    prev_byte_next     = prev_byte;
    in_lc_next         = in_lc;
    in_bc_next         = in_bc;
    com_on_line_next   = com_on_line;
    in_dq_next         = in_dq;
    in_sq_next         = in_sq;
    code_cnt_next      = code_cnt;
    first_punct_next   = first_punct;
    saw_any_next       = saw_any;
    comment_total_next = comment_total;
    code_total_next    = code_total;
    blank_total_next   = blank_total;
    out_load           = 1'b0;
    end_line           = 1'b0;
    empty_res          = 1'b0;
    lone_punct         = (code_cnt == 2'd1) && first_punct;

    if (pop && !it.is_end) begin
      saw_any_next = 1'b1;
      if (in_dq || in_sq) begin
        if (code_cnt == 2'd0) begin
          first_punct_next = it.is_punct;
        end
        if (code_cnt != slc_pkg::CODE_CNT_MAX) begin
          code_cnt_next = code_cnt + 2'd1;
        end
        if ((in_dq && it.is_dquote) || (in_sq && it.is_squote)) begin
          in_dq_next = 1'b0;
          in_sq_next = 1'b0;
        end
        prev_byte_next = it.byte_value;
      end else if (it.is_space) begin
        prev_byte_next = it.byte_value;
      end else if (it.is_nl) begin
        end_line       = 1'b1;
        prev_byte_next = it.byte_value;
      end else if (in_lc) begin
        com_on_line_next = 1'b1;
        prev_byte_next   = it.byte_value;
      end else if (in_bc) begin
        com_on_line_next = 1'b1;
        if (prev_byte == slc_pkg::CHAR_STAR && it.is_slash) begin
          in_bc_next     = 1'b0;
          prev_byte_next = 8'd0;
        end else begin
          prev_byte_next = it.byte_value;
        end
      end else if (prev_byte == slc_pkg::CHAR_SLASH && (it.is_slash || it.is_star)) begin
        // comment opener: take the first slash back out of the code part
        if (code_cnt != 2'd0) begin
          code_cnt_next = code_cnt - 2'd1;
        end
        in_bc_next       = it.is_star;
        in_lc_next       = it.is_slash;
        com_on_line_next = 1'b1;
        prev_byte_next   = 8'd0;
      end else begin
        if (code_cnt == 2'd0) begin
          first_punct_next = it.is_punct;
        end
        if (code_cnt != slc_pkg::CODE_CNT_MAX) begin
          code_cnt_next = code_cnt + 2'd1;
        end
        in_dq_next     = it.is_dquote;
        in_sq_next     = it.is_squote;
        prev_byte_next = it.byte_value;
      end
    end else if (pop) begin
      out_load  = 1'b1;
      end_line  = saw_any;
      empty_res = !saw_any;
    end

    if (end_line) begin
      if (com_on_line || in_lc || in_bc) begin
        comment_total_next = sat_inc(comment_total);
      end
      if (!com_on_line && (code_cnt == 2'd0 || lone_punct)) begin
        blank_total_next = sat_inc(blank_total);
      end
      if (code_cnt > 2'd1 || (code_cnt == 2'd1 && !first_punct)) begin
        code_total_next = sat_inc(code_total);
      end
      code_cnt_next    = 2'd0;
      first_punct_next = 1'b0;
      com_on_line_next = 1'b0;
      in_lc_next       = 1'b0;
    end

    comment_wide = 32'(comment_total_next);
    code_wide    = 32'(code_total_next);
    blank_wide   = 32'(blank_total_next);
  end

  always_ff @(posedge clk) begin
    if (rst || out_load) begin
      // end item returns the whole line state to its reset value
      prev_byte     <= 8'd0;
      in_lc         <= 1'b0;
      in_bc         <= 1'b0;
      com_on_line   <= 1'b0;
      in_dq         <= 1'b0;
      in_sq         <= 1'b0;
      code_cnt      <= 2'd0;
      first_punct   <= 1'b0;
      saw_any       <= 1'b0;
      comment_total <= '0;
      code_total    <= '0;
      blank_total   <= '0;
    end else begin
      prev_byte     <= prev_byte_next;
      in_lc         <= in_lc_next;
      in_bc         <= in_bc_next;
      com_on_line   <= com_on_line_next;
      in_dq         <= in_dq_next;
      in_sq         <= in_sq_next;
      code_cnt      <= code_cnt_next;
      first_punct   <= first_punct_next;
      saw_any       <= saw_any_next;
      comment_total <= comment_total_next;
      code_total    <= code_total_next;
      blank_total   <= blank_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (counts.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      comment_lines <= empty_res ? '0 : comment_wide[slc_pkg::OUT_BITS-1:0];
      code_lines    <= empty_res ? '0 : code_wide[slc_pkg::OUT_BITS-1:0];
      blank_lines   <= empty_res ? '0 : blank_wide[slc_pkg::OUT_BITS-1:0];
      empty_text    <= empty_res;
    end
  end

  assign counts.valid         = out_valid;
  assign counts.comment_lines = comment_lines;
  assign counts.code_lines    = code_lines;
  assign counts.blank_lines   = blank_lines;
  assign counts.empty_text    = empty_text;

endmodule

FILE: hw/rtl/source_line_classifier.sv
`timescale 1ns / 1ps
// Source line classifier: takes C text one byte per item, req_type 1 ends a text and
// returns one result with the comment, code and blank line counts and an empty flag.
// A byte item is taken every cycle while the queue is not full. The front end classifies
// each byte and writes it into a two-entry queue; the back end updates the line state one
// item per cycle and holds the result in an output register, so an end item stalls the
// back end only while an earlier result is still waiting to be taken. An accepted end
// item passes through the queue and its result is loaded into the output register.
// Counters are COUNT_BITS wide and saturate; results show their low 24 bits.
// Depends on slc_pkg, slc_ifs, slc_front, slc_queue and slc_back.
module source_line_classifier #(
  parameter int COUNT_BITS = slc_pkg::COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  slc_text_if.sink    text,
  slc_count_if.source counts
);

  logic           push;
  logic           pop;
  logic           queue_full;
  logic           head_valid;
  slc_pkg::item_t push_item;
  slc_pkg::item_t head_item;

  slc_front u_front (
    .rst        (rst),
    .text       (text),
    .queue_full (queue_full),
    .push       (push),
    .item       (push_item)
  );

  slc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  slc_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .counts     (counts)
  );

endmodule

FILE: hw/rtl/slc_checker.sv
`timescale 1ns / 1ps
// port-level checks for the source line classifier, bound to the top level
// depends on slc_pkg and source_line_classifier
module slc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_req_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_comment,
  input logic [23:0] out_code,
  input logic [23:0] out_blank,
  input logic        out_empty
);

  logic [3:0] pending;
  logic       end_in;
  logic       res_out;

  assign end_in  = in_valid && in_ready && (in_req_type == slc_pkg::REQ_END);
  assign res_out = out_valid && out_ready;

  // end items accepted whose result has not been taken yet
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 4'd0;
    end else begin
      case ({end_in, res_out})
        2'b10:   pending <= pending + 4'd1;
        2'b01:   pending <= pending - 4'd1;
        default: pending <= pending;
      endcase
    end
  end

  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 4'd0)
    else $error("result shown with no end item outstanding");

  a_empty_means_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_empty) |-> (out_comment == 24'd0 && out_code == 24'd0 &&
                                  out_blank == 24'd0))
    else $error("empty text result carries nonzero counts");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(out_comment) && $stable(out_code) &&
                                   $stable(out_blank) && $stable(out_empty)))
    else $error("stalled result changed");

endmodule

bind source_line_classifier slc_checker u_slc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (text.valid),
  .in_ready    (text.ready),
  .in_req_type (text.req_type),
  .out_valid   (counts.valid),
  .out_ready   (counts.ready),
  .out_comment (counts.comment_lines),
  .out_code    (counts.code_lines),
  .out_blank   (counts.blank_lines),
  .out_empty   (counts.empty_text)
);
